// ----- src/qrp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qrp_pkg
// Shared widths, register indexes and defaults of the quadratic residue
// permutation block.
// ----------------------------------------------------------------------------
package qrp_pkg;

  localparam int FIELD_W     = 64;
  localparam int DATA_W_DEF  = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_UNIVERSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEED     = 2'd2;

endpackage
`default_nettype wire

// ----- src/qrp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qrp interfaces
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface qrp_in_if
  import qrp_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] index_in;

  modport source (output valid, output index_in, input ready);
  modport sink (input valid, input index_in, output ready);
endinterface

interface qrp_out_if
  import qrp_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] permuted_index;

  modport source (output valid, output permuted_index, input ready);
  modport sink (input valid, input permuted_index, output ready);
endinterface

interface qrp_cfg_if
  import qrp_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FIELD_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- src/qrp_round.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qrp_round
// Pipelined quadratic residue map: x*x mod p by shift and add, one modular
// doubling or addition per stage, then the half-range fold; x >= p bypasses.
// ----------------------------------------------------------------------------
module qrp_round #(
  parameter int DW = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic [DW-1:0] prime,
  input  wire logic          in_valid,
  input  wire logic [DW-1:0] in_x,
  output logic               out_valid,
  output logic [DW-1:0]      out_y
);

  localparam int NS = 2 * DW;

  function automatic logic [DW-1:0] add_mod(input logic [DW-1:0] a, input logic [DW-1:0] b,
                                            input logic [DW-1:0] p);
    logic [DW-1:0] gap;
    gap = p - b;
    return (a >= gap) ? (a - gap) : (a + b);
  endfunction

  logic          v_r   [0:NS];
  logic [DW-1:0] x_r   [0:NS];
  logic [DW-1:0] acc_r [0:NS];
  logic          byp_r [0:NS];
  logic          neg_r [0:NS];
  logic          out_valid_r;
  logic [DW-1:0] out_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      x_r[0]   <= in_x;
      acc_r[0] <= '0;
      byp_r[0] <= (in_x >= prime);
      neg_r[0] <= (in_x > (prime >> 1));
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_stage
    localparam int BIT = DW - 1 - ((k - 1) / 2);
    logic [DW-1:0] acc_nxt;

    always_comb begin
      if ((k % 2) == 1) begin
        acc_nxt = add_mod(acc_r[k-1], acc_r[k-1], prime);
      end else if (x_r[k-1][BIT]) begin
        acc_nxt = add_mod(acc_r[k-1], x_r[k-1], prime);
      end else begin
        acc_nxt = acc_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
      if (en) begin
        x_r[k]   <= x_r[k-1];
        acc_r[k] <= acc_nxt;
        byp_r[k] <= byp_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[NS];
    end
    if (en) begin
      if (byp_r[NS]) begin
        out_y_r <= x_r[NS];
      end else if (neg_r[NS]) begin
        out_y_r <= prime - acc_r[NS];
      end else begin
        out_y_r <= acc_r[NS];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_y     = out_y_r;

endmodule
`default_nettype wire

// ----- src/qrp_mod.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qrp_mod
// Adds the seed with wraparound, then reduces modulo the universe size by
// restoring division, one quotient bit per stage; a zero universe bypasses.
// ----------------------------------------------------------------------------
module qrp_mod #(
  parameter int DW = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic [DW-1:0] universe,
  input  wire logic [DW-1:0] seed,
  input  wire logic          in_valid,
  input  wire logic [DW-1:0] in_a,
  output logic               out_valid,
  output logic [DW-1:0]      out_r
);

  logic          v_r   [0:DW];
  logic [DW-1:0] a_r   [0:DW];
  logic [DW:0]   rem_r [0:DW];
  logic          out_valid_r;
  logic [DW-1:0] out_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      a_r[0]   <= seed + in_a;
      rem_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= DW; k++) begin : g_stage
    localparam int BIT = DW - k;
    logic [DW:0] shl;
    logic [DW:0] rem_nxt;

    always_comb begin
      shl = {rem_r[k-1][DW-1:0], a_r[k-1][BIT]};
      if (shl >= {1'b0, universe}) begin
        rem_nxt = shl - {1'b0, universe};
      end else begin
        rem_nxt = shl;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
      if (en) begin
        a_r[k]   <= a_r[k-1];
        rem_r[k] <= rem_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[DW];
    end
    if (en) begin
      out_r_r <= (universe == '0) ? a_r[DW] : rem_r[DW][DW-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_r     = out_r_r;

endmodule
`default_nettype wire

// ----- src/quadratic_residue_permutation.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_residue_permutation
// Two rounds of a quadratic residue map with a seed addition and a modular
// reduction between them, fully pipelined.
// ----------------------------------------------------------------------------
// Channel   Direction  Carries
// in_ch     sink       index_in word
// out_ch    source     permuted_index word
// cfg_ch    sink       register index and data, ready whenever out of reset
//
// One word enters per cycle unless the output stalls; the pipeline depth is
// set by the two shift-and-add squaring chains and the restoring divider.
// Reset clears all stage valid bits and loads the register defaults.
// A stalled output freezes every stage at once; bubbles are kept in place.
// ----------------------------------------------------------------------------
module quadratic_residue_permutation
  import qrp_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_W_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  qrp_in_if.sink    in_ch,
  qrp_out_if.source out_ch,
  qrp_cfg_if.sink   cfg_ch
);

  logic [DATA_WIDTH-1:0] universe_r;
  logic [DATA_WIDTH-1:0] prime_r;
  logic [DATA_WIDTH-1:0] seed_r;
  logic                  en;
  logic                  r1_valid;
  logic [DATA_WIDTH-1:0] r1_y;
  logic                  md_valid;
  logic [DATA_WIDTH-1:0] md_r;
  logic                  r2_valid;
  logic [DATA_WIDTH-1:0] r2_y;

  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      universe_r <= DATA_WIDTH'(1);
      prime_r    <= '0;
      seed_r     <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_UNIVERSE: universe_r <= cfg_ch.data[DATA_WIDTH-1:0];
        REG_PRIME:    prime_r    <= cfg_ch.data[DATA_WIDTH-1:0];
        REG_SEED:     seed_r     <= cfg_ch.data[DATA_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  assign en          = !r2_valid || out_ch.ready;
  assign in_ch.ready = en && rst_n;

  qrp_round #(.DW(DATA_WIDTH)) u_round1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .prime     (prime_r),
    .in_valid  (in_ch.valid),
    .in_x      (in_ch.index_in[DATA_WIDTH-1:0]),
    .out_valid (r1_valid),
    .out_y     (r1_y)
  );

  qrp_mod #(.DW(DATA_WIDTH)) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .universe  (universe_r),
    .seed      (seed_r),
    .in_valid  (r1_valid),
    .in_a      (r1_y),
    .out_valid (md_valid),
    .out_r     (md_r)
  );

  qrp_round #(.DW(DATA_WIDTH)) u_round2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .prime     (prime_r),
    .in_valid  (md_valid),
    .in_x      (md_r),
    .out_valid (r2_valid),
    .out_y     (r2_y)
  );

  assign out_ch.valid          = r2_valid;
  assign out_ch.permuted_index = FIELD_W'(r2_y);

endmodule
`default_nettype wire
